[rtl/btsc_pkg.sv]
// Shared types and constants for the binary trie string counter.
`default_nettype none
package btsc_pkg;

  localparam int BitsPerChar = 8;
  localparam int BitIdxW     = $clog2(BitsPerChar);
  localparam int CountW      = 32;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_RD,
    ST_CHK,
    ST_LINK,
    ST_END,
    ST_CRD,
    ST_CUPD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic rd_link;
    logic advance;
    logic alloc_clear;
    logic set_ovf;
    logic link_write;
    logic rd_count;
    logic finish_count;
    logic finish_full;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic last;
    logic overflow;
    logic link_zero;
    logic pool_full;
    logic last_bit;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/btsc_in_if.sv]
// Input channel: one string byte word with its command and flags.
`default_nettype none
interface btsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_byte;
  logic       last;
  logic       empty_string;

  modport source (output valid, output cmd, output char_byte, output last,
                  output empty_string, input ready);
  modport sink (input valid, input cmd, input char_byte, input last,
                input empty_string, output ready);
endinterface
`default_nettype wire

[rtl/btsc_out_if.sv]
// Result channel: the string count and the pool-full flag.
`default_nettype none
interface btsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] count;
  logic               full_res;

  modport source (output valid, output count, output full_res, input ready);
  modport sink (input valid, input count, input full_res, output ready);
endinterface
`default_nettype wire

[rtl/btsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module btsc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/btsc_ctrl.sv]
// Controller state machine that sequences the trie walk and count update.
`default_nettype none
module btsc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire btsc_pkg::dp_status_t  status,
  output btsc_pkg::ctrl_cmd_t        cmd
);

  btsc_pkg::state_t state_r;
  btsc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      btsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = btsc_pkg::ST_DISP;
        end
      end
      btsc_pkg::ST_DISP: begin
        if (!status.empty && !status.overflow) begin
          state_nxt = btsc_pkg::ST_RD;
        end else if (status.last) begin
          state_nxt = btsc_pkg::ST_END;
        end else begin
          state_nxt = btsc_pkg::ST_IDLE;
        end
      end
      btsc_pkg::ST_RD: begin
        state_nxt = btsc_pkg::ST_CHK;
      end
      btsc_pkg::ST_CHK: begin
        if (!status.link_zero) begin
          if (!status.last_bit) begin
            state_nxt = btsc_pkg::ST_RD;
          end else if (status.last) begin
            state_nxt = btsc_pkg::ST_END;
          end else begin
            state_nxt = btsc_pkg::ST_IDLE;
          end
        end else if (status.pool_full) begin
          state_nxt = status.last ? btsc_pkg::ST_END : btsc_pkg::ST_IDLE;
        end else begin
          state_nxt = btsc_pkg::ST_LINK;
        end
      end
      btsc_pkg::ST_LINK: begin
        if (!status.last_bit) begin
          state_nxt = btsc_pkg::ST_RD;
        end else if (status.last) begin
          state_nxt = btsc_pkg::ST_END;
        end else begin
          state_nxt = btsc_pkg::ST_IDLE;
        end
      end
      btsc_pkg::ST_END: begin
        if (status.overflow) begin
          if (!status.out_busy) begin
            state_nxt = btsc_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = btsc_pkg::ST_CRD;
        end
      end
      btsc_pkg::ST_CRD: begin
        state_nxt = btsc_pkg::ST_CUPD;
      end
      btsc_pkg::ST_CUPD: begin
        if (!status.out_busy) begin
          state_nxt = btsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = btsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      btsc_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      btsc_pkg::ST_RD: begin
        cmd.rd_link = 1'b1;
      end
      btsc_pkg::ST_CHK: begin
        if (!status.link_zero) begin
          cmd.advance = 1'b1;
        end else if (status.pool_full) begin
          cmd.set_ovf = 1'b1;
        end else begin
          cmd.alloc_clear = 1'b1;
        end
      end
      btsc_pkg::ST_LINK: begin
        cmd.link_write = 1'b1;
      end
      btsc_pkg::ST_END: begin
        cmd.finish_full = status.overflow && !status.out_busy;
      end
      btsc_pkg::ST_CRD: begin
        cmd.rd_count = 1'b1;
      end
      btsc_pkg::ST_CUPD: begin
        cmd.finish_count = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/btsc_dp.sv]
// Datapath: item registers, walk cursor, node pool, root node and result word.
`default_nettype none
module btsc_dp #(
  parameter int NODES = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire btsc_pkg::ctrl_cmd_t   cmd,
  output btsc_pkg::dp_status_t       status,
  input  wire logic                  in_valid,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [7:0]            in_char_byte,
  input  wire logic                  in_last,
  input  wire logic                  in_empty_string,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [31:0]         out_count,
  output logic                       out_full_res
);

  localparam int IW = $clog2(NODES);
  localparam int FW = $clog2(NODES + 1);
  localparam int BW = btsc_pkg::BitIdxW;
  localparam int CW = btsc_pkg::CountW;
  localparam logic [FW-1:0] PoolEnd = FW'(NODES);
  localparam logic [FW-1:0] FreeOne = FW'(1);
  localparam logic [BW-1:0] LastBit = BW'(btsc_pkg::BitsPerChar - 1);
  localparam logic [BW-1:0] BitOne  = BW'(1);
  localparam logic [CW-1:0] CountOne = CW'(1);

  // Latched item.
  logic [1:0] cmd_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       empty_r;

  // Walk state.
  logic [IW-1:0]                 cursor_r;
  logic [FW-1:0]                 next_free_r;
  logic                          ovf_r;
  logic [btsc_pkg::BitIdxW-1:0]  bit_idx_r;

  // The root lives in flip-flops so that reset defines it.
  logic [IW-1:0]                 root_zero_r;
  logic [IW-1:0]                 root_one_r;
  logic [btsc_pkg::CountW-1:0]   root_count_r;

  logic                          out_valid_r;
  logic [btsc_pkg::CountW-1:0]   out_count_r;
  logic                          out_full_r;

  logic                          cz_we, co_we, cn_we;
  logic [IW-1:0]                 cz_waddr, co_waddr, cn_waddr;
  logic [IW-1:0]                 cz_wdata, co_wdata;
  logic [btsc_pkg::CountW-1:0]   cn_wdata;
  logic [IW-1:0]                 cz_rdata, co_rdata;
  logic [btsc_pkg::CountW-1:0]   cn_rdata;

  logic                          cur_bit;
  logic                          at_root;
  logic [IW-1:0]                 link_val;
  logic [IW-1:0]                 new_node;
  logic [btsc_pkg::CountW-1:0]   cur_count;
  logic [btsc_pkg::CountW-1:0]   new_count;
  logic                          in_take;

  assign in_take  = in_valid && cmd.in_ready;
  assign cur_bit  = byte_r[bit_idx_r];
  assign at_root  = (cursor_r == '0);
  assign new_node = next_free_r[IW-1:0];

  always_comb begin
    if (at_root) begin
      link_val = cur_bit ? root_one_r : root_zero_r;
    end else begin
      link_val = cur_bit ? co_rdata : cz_rdata;
    end
  end

  assign cur_count = at_root ? root_count_r : cn_rdata;

  always_comb begin
    case (cmd_r)
      btsc_pkg::CMD_ADD:    new_count = cur_count + CountOne;
      btsc_pkg::CMD_REMOVE: new_count = cur_count - CountOne;
      default:              new_count = cur_count;
    endcase
  end

  // Memory write ports. A freshly allocated node gets all three entries
  // cleared first; its parent's link is written in the following cycle.
  always_comb begin
    cz_we    = 1'b0;
    co_we    = 1'b0;
    cn_we    = 1'b0;
    cz_waddr = new_node;
    co_waddr = new_node;
    cn_waddr = new_node;
    cz_wdata = '0;
    co_wdata = '0;
    cn_wdata = '0;
    if (cmd.alloc_clear) begin
      cz_we = 1'b1;
      co_we = 1'b1;
      cn_we = 1'b1;
    end else if (cmd.link_write && !at_root) begin
      if (cur_bit) begin
        co_we    = 1'b1;
        co_waddr = cursor_r;
        co_wdata = new_node;
      end else begin
        cz_we    = 1'b1;
        cz_waddr = cursor_r;
        cz_wdata = new_node;
      end
    end else if (cmd.finish_count && !at_root) begin
      cn_we    = 1'b1;
      cn_waddr = cursor_r;
      cn_wdata = new_count;
    end
  end

  btsc_ram #(.WIDTH(IW), .DEPTH(NODES)) u_child_zero (
    .clk   (clk),
    .we    (cz_we),
    .waddr (cz_waddr),
    .wdata (cz_wdata),
    .re    (cmd.rd_link),
    .raddr (cursor_r),
    .rdata (cz_rdata)
  );

  btsc_ram #(.WIDTH(IW), .DEPTH(NODES)) u_child_one (
    .clk   (clk),
    .we    (co_we),
    .waddr (co_waddr),
    .wdata (co_wdata),
    .re    (cmd.rd_link),
    .raddr (cursor_r),
    .rdata (co_rdata)
  );

  btsc_ram #(.WIDTH(btsc_pkg::CountW), .DEPTH(NODES)) u_node_count (
    .clk   (clk),
    .we    (cn_we),
    .waddr (cn_waddr),
    .wdata (cn_wdata),
    .re    (cmd.rd_count),
    .raddr (cursor_r),
    .rdata (cn_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= in_cmd;
      byte_r  <= in_char_byte;
      last_r  <= in_last;
      empty_r <= in_empty_string;
    end
    if (cmd.finish_count) begin
      out_count_r <= new_count;
      out_full_r  <= 1'b0;
    end else if (cmd.finish_full) begin
      out_count_r <= '0;
      out_full_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      next_free_r  <= FreeOne;
      ovf_r        <= 1'b0;
      bit_idx_r    <= '0;
      root_zero_r  <= '0;
      root_one_r   <= '0;
      root_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        bit_idx_r <= '0;
      end
      if (cmd.advance) begin
        cursor_r  <= link_val;
        bit_idx_r <= bit_idx_r + BitOne;
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.link_write) begin
        if (at_root) begin
          if (cur_bit) begin
            root_one_r <= new_node;
          end else begin
            root_zero_r <= new_node;
          end
        end
        cursor_r    <= new_node;
        next_free_r <= next_free_r + FreeOne;
        bit_idx_r   <= bit_idx_r + BitOne;
      end
      if (cmd.finish_count && at_root) begin
        root_count_r <= new_count;
      end
      if (cmd.finish_count || cmd.finish_full) begin
        cursor_r    <= '0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status.empty     = empty_r;
    status.last      = last_r;
    status.overflow  = ovf_r;
    status.link_zero = (link_val == '0);
    status.pool_full = (next_free_r == PoolEnd);
    status.last_bit  = (bit_idx_r == LastBit);
    status.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_count    = out_count_r;
  assign out_full_res = out_full_r;

endmodule
`default_nettype wire

[rtl/binary_trie_string_counter.sv]
// Binary trie string counter: a multiset of byte strings.
// After acceptance a byte word passes a dispatch state, then a link read and a check per trie
// level, plus a link write per newly allocated node. The last word adds end, count read and
// update states, or only the end state if the pool ran out. A new word is accepted only once
// the last is through; a stalled result holds the input. Reset is synchronous: only the root
// exists afterward; no clearing pass.
`default_nettype none
module binary_trie_string_counter #(
  parameter int NODES = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  btsc_in_if.sink     in_chan,
  btsc_out_if.source  out_chan
);

  btsc_pkg::ctrl_cmd_t  cmd;
  btsc_pkg::dp_status_t status;

  btsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .status   (status),
    .cmd      (cmd)
  );

  btsc_dp #(.NODES(NODES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_valid        (in_chan.valid),
    .in_cmd          (in_chan.cmd),
    .in_char_byte    (in_chan.char_byte),
    .in_last         (in_chan.last),
    .in_empty_string (in_chan.empty_string),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_count       (out_chan.count),
    .out_full_res    (out_chan.full_res)
  );

  assign in_chan.ready = cmd.in_ready;

endmodule
`default_nettype wire
